>>> src/laplacian_cross_stencil_core_macros.svh
// Assertion macros shared by the stencil checkers.
// Every macro samples on the rising edge of clock.
`ifndef LAPLACIAN_CROSS_STENCIL_CORE_MACROS_SVH
`define LAPLACIAN_CROSS_STENCIL_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent, outside reset.
`define LCS_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("laplacian stencil check failed");

// The consequent must hold in the cycle after the antecedent, outside reset.
`define LCS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("laplacian stencil check failed");

// The consequent must hold in the cycle after reset is seen high.
`define LCS_ASSERT_AFTER_RESET(label, cons) \
   label: assert property (@(posedge clock) reset |=> (cons)) \
      else $error("laplacian stencil reset check failed");

`endif

>>> src/lcs_pkg.sv
// ----------------------------------------------------------------------------
// lcs_pkg
// Types and constants shared by the five-point Laplacian stencil modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lcs_pkg;

   localparam int MAX_WIDTH    = 1024;
   localparam int COL_BITS     = $clog2(MAX_WIDTH);
   localparam int PIXEL_BITS   = 16;
   localparam int ROW_BITS     = 16;
   localparam int FW_BITS      = 11;
   localparam int CSR_BITS     = 16;
   localparam int LAP_BITS     = 19;
   localparam int OUT_COL_BITS = 10;

   localparam int RESET_WIDTH  = 640;
   localparam int RESET_HEIGHT = 480;

   // Register indexes of the configuration port.
   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   // Results an input word can cause, in the order they leave the block.
   localparam logic [2:0] RES_ABOVE  = 3'b001;  // pixel one row up, same column
   localparam logic [2:0] RES_LEFT   = 3'b010;  // bottom row, one column left
   localparam logic [2:0] RES_CORNER = 3'b100;  // bottom-right pixel itself

   typedef struct packed {
      logic [PIXEL_BITS-1:0] upper;
      logic [PIXEL_BITS-1:0] middle;
   } line_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] pixel;
      logic [COL_BITS-1:0]   col;
      logic [ROW_BITS-1:0]   row;
      logic                  first_col;
      logic                  second_col;
      logic                  last_col;
      logic                  row_one;
      logic [2:0]            pend;
   } item_type;

endpackage

`default_nettype wire

>>> src/lcs_ram.sv
// ----------------------------------------------------------------------------
// lcs_ram
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lcs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> src/lcs_scan.sv
// ----------------------------------------------------------------------------
// lcs_scan
// Frame geometry registers, raster counters and the line store. Each accepted
// word writes its column and prefetches the next column for the stencil.
// ----------------------------------------------------------------------------
`default_nettype none

module lcs_scan import lcs_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic                  csr_index,
   input  wire logic [CSR_BITS-1:0]   csr_wdata,
   input  wire logic                  accept,
   input  wire logic [PIXEL_BITS-1:0] req_pixel,
   output item_type                   item,
   output line_type                   line_rd
);

   logic [COL_BITS-1:0] w_last_ff, w_last_in;
   logic [ROW_BITS-1:0] h_last_ff, h_last_in;
   logic [COL_BITS-1:0] col_ff, col_in;
   logic [ROW_BITS-1:0] row_ff, row_in;

   logic [FW_BITS-1:0]  fw;
   logic [ROW_BITS-1:0] fh;
   logic [COL_BITS-1:0] fw_last;
   logic [ROW_BITS-1:0] fh_last;
   logic                last_col;
   logic                bot_row;
   logic [COL_BITS-1:0] nxt_col;
   line_type            wr_line;

   assign fw = csr_wdata[FW_BITS-1:0];
   assign fh = csr_wdata[ROW_BITS-1:0];

   // Widths below two act as two, widths above the line store as its depth.
   always_comb begin
      if (fw < FW_BITS'(2)) begin
         fw_last = COL_BITS'(1);
      end else if (32'(fw) > MAX_WIDTH) begin
         fw_last = COL_BITS'(MAX_WIDTH - 1);
      end else begin
         fw_last = COL_BITS'(fw - FW_BITS'(1));
      end
   end

   assign fh_last  = (fh < ROW_BITS'(2)) ? ROW_BITS'(1) : fh - ROW_BITS'(1);
   assign last_col = (col_ff == w_last_ff);
   assign bot_row  = (row_ff == h_last_ff);
   assign nxt_col  = last_col ? '0 : col_ff + COL_BITS'(1);

   always_comb begin
      w_last_in = w_last_ff;
      h_last_in = h_last_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FRAME_WIDTH: begin
               w_last_in = fw_last;
               col_in    = '0;
               row_in    = '0;
            end
            CSR_FRAME_HEIGHT: begin
               h_last_in = fh_last;
               col_in    = '0;
               row_in    = '0;
            end
            default: begin
               col_in = col_ff;
            end
         endcase
      end else if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = bot_row ? '0 : row_ff + ROW_BITS'(1);
         end else begin
            col_in = col_ff + COL_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_last_ff <= COL_BITS'(RESET_WIDTH - 1);
         h_last_ff <= ROW_BITS'(RESET_HEIGHT - 1);
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         w_last_ff <= w_last_in;
         h_last_ff <= h_last_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

   always_comb begin
      item.pixel      = req_pixel;
      item.col        = col_ff;
      item.row        = row_ff;
      item.first_col  = (col_ff == '0);
      item.second_col = (col_ff == COL_BITS'(1));
      item.last_col   = last_col;
      item.row_one    = (row_ff == ROW_BITS'(1));
      item.pend       = '0;
      if (row_ff != '0) begin
         item.pend = item.pend | RES_ABOVE;
      end
      if (bot_row && (col_ff != '0)) begin
         item.pend = item.pend | RES_LEFT;
      end
      if (bot_row && last_col) begin
         item.pend = item.pend | RES_CORNER;
      end
   end

   // The read data holds the current column, prefetched by the previous word;
   // its middle row moves up as the new pixel enters.
   assign wr_line.upper  = line_rd.middle;
   assign wr_line.middle = req_pixel;

   lcs_ram #(
      .WIDTH ($bits(line_type)),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_ff),
      .wr_data (wr_line),
      .rd_en   (accept),
      .rd_addr (nxt_col),
      .rd_data (line_rd)
   );

endmodule

`default_nettype wire

>>> src/lcs_emit.sv
// ----------------------------------------------------------------------------
// lcs_emit
// Stencil window, result sequencer and output register. Each held word gives
// up to three results, one per cycle unless the output stalls, through one shared adder.
// ----------------------------------------------------------------------------
`default_nettype none

module lcs_emit import lcs_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    accept,
   input  wire item_type                item,
   input  wire line_type                line_rd,
   output logic                         take_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic signed [LAP_BITS-1:0]   rsp_laplace_value,
   output logic        [OUT_COL_BITS-1:0] rsp_out_col,
   output logic        [ROW_BITS-1:0]   rsp_out_row,
   output logic                         rsp_last_in_run,
   output logic                         rsp_end_of_frame
);

   logic [2:0]            pend_ff, pend_in;
   item_type              cur_ff;
   logic [PIXEL_BITS-1:0] m_ff, u_ff, lm_ff, lp_ff, lp2_ff;

   logic [2:0]            sel;
   logic [2:0]            rest;
   logic                  fire;
   logic [PIXEL_BITS-1:0] nxt_m;

   logic [PIXEL_BITS-1:0] op_ctr, op_lf, op_rt, op_up, op_dn;
   logic [COL_BITS-1:0]   res_col;
   logic [ROW_BITS-1:0]   res_row;
   logic                  res_eof;
   logic [LAP_BITS-1:0]   lap_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [LAP_BITS-1:0]   lap_ff;
   logic [OUT_COL_BITS-1:0] col_ff;
   logic [ROW_BITS-1:0]   row_ff;
   logic                  last_ff, eof_ff;

   // While a word is held, the read port shows the next column, wrapping to column zero.
   assign nxt_m = line_rd.middle;

   assign sel        = pend_ff & (~pend_ff + 3'd1);
   assign rest       = pend_ff & ~sel;
   assign fire       = (pend_ff != 3'b000) && (!rsp_valid_ff || rsp_ready);
   assign take_ready = (pend_ff == 3'b000) || (fire && (rest == 3'b000));

   always_comb begin
      pend_in = pend_ff;
      if (accept) begin
         pend_in = item.pend;
      end else if (fire) begin
         pend_in = rest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // Window: the held column plus the one and two columns before it.
   always_ff @(posedge clock) begin
      if (accept) begin
         cur_ff <= item;
         m_ff   <= line_rd.middle;
         u_ff   <= line_rd.upper;
         lm_ff  <= m_ff;
         lp_ff  <= cur_ff.pixel;
         lp2_ff <= lp_ff;
      end
   end

   always_comb begin
      op_ctr  = cur_ff.pixel;
      op_lf   = lp_ff;
      op_rt   = cur_ff.pixel;
      op_up   = m_ff;
      op_dn   = cur_ff.pixel;
      res_col = cur_ff.col;
      res_row = cur_ff.row;
      res_eof = 1'b0;
      case (sel)
         RES_ABOVE: begin
            // Top edge mirrors row one, which is the incoming row here.
            op_ctr  = m_ff;
            op_up   = cur_ff.row_one ? cur_ff.pixel : u_ff;
            op_lf   = cur_ff.first_col ? nxt_m : lm_ff;
            op_rt   = cur_ff.last_col ? m_ff : nxt_m;
            op_dn   = cur_ff.pixel;
            res_row = cur_ff.row - ROW_BITS'(1);
         end
         RES_LEFT: begin
            op_ctr  = lp_ff;
            op_lf   = cur_ff.second_col ? cur_ff.pixel : lp2_ff;
            op_rt   = cur_ff.pixel;
            op_up   = lm_ff;
            op_dn   = lp_ff;
            res_col = cur_ff.col - COL_BITS'(1);
         end
         RES_CORNER: begin
            res_eof = 1'b1;
         end
         default: begin
            res_eof = 1'b0;
         end
      endcase
   end

   assign lap_in = (LAP_BITS'(op_ctr) << 2) - LAP_BITS'(op_lf) - LAP_BITS'(op_rt)
                   - LAP_BITS'(op_up) - LAP_BITS'(op_dn);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         lap_ff  <= lap_in;
         col_ff  <= OUT_COL_BITS'(res_col);
         row_ff  <= res_row;
         last_ff <= (rest == 3'b000);
         eof_ff  <= res_eof;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_laplace_value = lap_ff;
   assign rsp_out_col       = col_ff;
   assign rsp_out_row       = row_ff;
   assign rsp_last_in_run   = last_ff;
   assign rsp_end_of_frame  = eof_ff;

endmodule

`default_nettype wire

>>> src/laplacian_cross_stencil_core.sv
// A result is formed from the registered window of its word and passes the output register.
// Throughput: one pixel per cycle unless the output stalls; on the bottom row a word is held
// until its results pass: one for its first pixel, two for each further pixel and three at
// the bottom-right pixel, since the single output register passes one result a cycle.
// Reset: synchronous; restores a 640 by 480 frame and the raster position to the top left.
// The line store is not cleared; every entry is written before it is used.
// ----------------------------------------------------------------------------
// laplacian_cross_stencil_core
// Five-point Laplacian over a raster-order pixel stream, with one line store
// holding the two previous rows and a window of registers across columns.
// ----------------------------------------------------------------------------
`default_nettype none

module laplacian_cross_stencil_core import lcs_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_we,
   input  wire logic                      csr_index,
   input  wire logic [CSR_BITS-1:0]       csr_wdata,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [PIXEL_BITS-1:0]     req_pixel,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic signed [LAP_BITS-1:0]     rsp_laplace_value,
   output logic        [OUT_COL_BITS-1:0] rsp_out_col,
   output logic        [ROW_BITS-1:0]     rsp_out_row,
   output logic                           rsp_last_in_run,
   output logic                           rsp_end_of_frame
);

   item_type item;
   line_type line_rd;
   logic     take_ready;
   logic     accept;

   assign req_ready = take_ready;
   assign accept    = req_valid && take_ready;

   lcs_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .req_pixel (req_pixel),
      .item      (item),
      .line_rd   (line_rd)
   );

   lcs_emit u_emit (
      .clock             (clock),
      .reset             (reset),
      .accept            (accept),
      .item              (item),
      .line_rd           (line_rd),
      .take_ready        (take_ready),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_laplace_value (rsp_laplace_value),
      .rsp_out_col       (rsp_out_col),
      .rsp_out_row       (rsp_out_row),
      .rsp_last_in_run   (rsp_last_in_run),
      .rsp_end_of_frame  (rsp_end_of_frame)
   );

endmodule

`default_nettype wire

>>> src/lcs_checker.sv
// ----------------------------------------------------------------------------
// lcs_checker
// Port-level checks of the stencil core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "laplacian_cross_stencil_core_macros.svh"

module lcs_checker import lcs_pkg::*; (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_ready,
   input wire logic signed [LAP_BITS-1:0] rsp_laplace_value,
   input wire logic [OUT_COL_BITS-1:0]   rsp_out_col,
   input wire logic [ROW_BITS-1:0]       rsp_out_row,
   input wire logic                      rsp_last_in_run,
   input wire logic                      rsp_end_of_frame
);

   // The frame end closes the run of results of its word.
   `LCS_ASSERT_SAME(eof_closes_run, rsp_valid && rsp_end_of_frame, rsp_last_in_run)

   // Frames are at least two pixels wide, so the corner never sits in column zero.
   `LCS_ASSERT_SAME(eof_not_first_col, rsp_valid && rsp_end_of_frame, rsp_out_col != '0)

   // The rest of a run follows without a gap once a result is taken.
   `LCS_ASSERT_NEXT(run_no_gap, rsp_valid && rsp_ready && !rsp_last_in_run, rsp_valid)

   // A stalled result holds its value.
   `LCS_ASSERT_NEXT(rsp_hold, rsp_valid && !rsp_ready,
                    rsp_valid && $stable(rsp_laplace_value) && $stable(rsp_out_row))

   `LCS_ASSERT_AFTER_RESET(reset_empties_output, !rsp_valid)

endmodule

bind laplacian_cross_stencil_core lcs_checker u_lcs_checker (.*);

`default_nettype wire

>>> tb/laplacian_cross_stencil_core_tb.sv
// ----------------------------------------------------------------------------
// laplacian_cross_stencil_core_tb
// Self-checking bench for the five-point Laplacian stencil. A directed table
// covers the reset frame, the value extremes and the register clamping. Random
// frames of small size follow.
// Each result word is checked against a cycle-free model of the stencil or a hand-given value.
// ----------------------------------------------------------------------------
module laplacian_cross_stencil_core_tb;
   import lcs_pkg::*;

   typedef struct packed {
      logic signed [LAP_BITS-1:0] value;
      logic [OUT_COL_BITS-1:0]    col;
      logic [ROW_BITS-1:0]        row;
      logic                       last;
      logic                       eof;
   } laplace_result_t;

   typedef enum logic {ROW_CSR, ROW_PIXEL} row_kind_t;

   typedef struct {
      row_kind_t         kind;
      logic              csr_sel;
      logic [CSR_BITS-1:0] data;
      bit                typed;
      bit                typed_hit;
      laplace_result_t   typed_res;
   } stim_row_t;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_we = 1'b0;
   logic                    csr_index = 1'b0;
   logic [CSR_BITS-1:0]     csr_wdata = '0;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [PIXEL_BITS-1:0]   req_pixel = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b1;
   logic signed [LAP_BITS-1:0] rsp_laplace_value;
   logic [OUT_COL_BITS-1:0] rsp_out_col;
   logic [ROW_BITS-1:0]     rsp_out_row;
   logic                    rsp_last_in_run;
   logic                    rsp_end_of_frame;

   // Model of the stencil: register copies, raster position and two line stores.
   logic [FW_BITS-1:0]      model_width;
   logic [ROW_BITS-1:0]     model_height;
   int                      next_col;
   int                      next_row;
   logic [PIXEL_BITS-1:0]   upper_rows  [0:MAX_WIDTH-1];
   logic [PIXEL_BITS-1:0]   middle_rows [0:MAX_WIDTH-1];

   laplace_result_t         pending_results[$];
   int                      mismatch_count = 0;
   int                      tx_idle_pct = 0;
   int                      rx_idle_pct = 0;
   bit                      quiet = 1'b0;
   int                      rx_stall_left = 0;

   laplacian_cross_stencil_core dut (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_pixel         (req_pixel),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_laplace_value (rsp_laplace_value),
      .rsp_out_col       (rsp_out_col),
      .rsp_out_row       (rsp_out_row),
      .rsp_last_in_run   (rsp_last_in_run),
      .rsp_end_of_frame  (rsp_end_of_frame)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int eff_width();
      if (model_width < 2) return 2;
      if (model_width > MAX_WIDTH) return MAX_WIDTH;
      return int'(model_width);
   endfunction

   function automatic int eff_height();
      return (model_height < 2) ? 2 : int'(model_height);
   endfunction

   function automatic laplace_result_t laplace_at(int ctr, int lf, int rt, int up, int dn,
                                                  int col, int row, bit eof);
      laplace_result_t res;
      int v;
      v = 4 * ctr - lf - rt - up - dn;
      res.value = v[LAP_BITS-1:0];
      res.col   = col[OUT_COL_BITS-1:0];
      res.row   = row[ROW_BITS-1:0];
      res.last  = 1'b0;
      res.eof   = eof;
      return res;
   endfunction

   // Advances the model by one pixel and returns the results it causes, in order.
   function automatic int stencil_step(input logic [PIXEL_BITS-1:0] pix,
                                       output laplace_result_t res[3]);
      int w, h, c, r, x, n, p, ctr, up, lf, rt;
      w = eff_width();
      h = eff_height();
      c = next_col;
      r = next_row;
      p = pix;
      n = 0;
      if (r >= 1) begin
         // The pixel one row up is now complete; the new pixel is its lower neighbor.
         ctr = middle_rows[c];
         up  = (r == 1) ? p : upper_rows[c];
         lf  = (c == 0) ? middle_rows[1] : upper_rows[c-1];
         rt  = (c == w - 1) ? ctr : middle_rows[c+1];
         res[n] = laplace_at(ctr, lf, rt, up, p, c, r - 1, 1'b0);
         n++;
      end
      upper_rows[c]  = middle_rows[c];
      middle_rows[c] = pix;
      if (r == h - 1) begin
         if (c >= 1) begin
            x   = c - 1;
            ctr = middle_rows[x];
            lf  = (x == 0) ? middle_rows[1] : middle_rows[x-1];
            res[n] = laplace_at(ctr, lf, middle_rows[c], upper_rows[x], ctr, x, r, 1'b0);
            n++;
         end
         if (c == w - 1) begin
            res[n] = laplace_at(p, middle_rows[c-1], p, upper_rows[c], p, c, r, 1'b1);
            n++;
         end
      end
      if (n > 0) res[n-1].last = 1'b1;
      if (c + 1 >= w) begin
         next_col = 0;
         next_row = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         next_col = c + 1;
      end
      return n;
   endfunction

   function automatic stim_row_t csr_row(logic sel, logic [CSR_BITS-1:0] data);
      stim_row_t s;
      s.kind      = ROW_CSR;
      s.csr_sel   = sel;
      s.data      = data;
      s.typed     = 1'b0;
      s.typed_hit = 1'b0;
      s.typed_res = '0;
      return s;
   endfunction

   function automatic stim_row_t pix_row(logic [PIXEL_BITS-1:0] pix);
      stim_row_t s;
      s = csr_row(1'b0, pix);
      s.kind = ROW_PIXEL;
      return s;
   endfunction

   // Pixel whose word causes no result at all.
   function automatic stim_row_t pix_none(logic [PIXEL_BITS-1:0] pix);
      stim_row_t s;
      s = pix_row(pix);
      s.typed = 1'b1;
      return s;
   endfunction

   // Pixel whose word causes exactly one result, given here by hand.
   function automatic stim_row_t pix_one(logic [PIXEL_BITS-1:0] pix, int value, int col,
                                         int row, bit eof);
      stim_row_t s;
      s = pix_none(pix);
      s.typed_hit = 1'b1;
      s.typed_res = laplace_at(value, 0, 0, 0, 0, col, row, eof);
      s.typed_res.value = value[LAP_BITS-1:0];
      s.typed_res.last  = 1'b1;
      return s;
   endfunction

   function automatic logic [PIXEL_BITS-1:0] rand_pixel();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return PIXEL_BITS'($urandom);
      endcase
   endfunction

   function automatic void compare_field(string name, longint want, longint got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endfunction

   task automatic wait_for_results();
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic send_pixel(input logic [PIXEL_BITS-1:0] pix, input bit typed,
                             input bit typed_hit, input laplace_result_t typed_res);
      laplace_result_t res[3];
      int n;
      if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= pix;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      n = stencil_step(pix, res);
      if (typed) begin
         if (typed_hit) pending_results.push_back(typed_res);
      end else begin
         for (int i = 0; i < n; i++) pending_results.push_back(res[i]);
      end
   endtask

   // Registers change only with the block drained and settled.
   task automatic write_register(input logic sel, input logic [CSR_BITS-1:0] data);
      req_valid <= 1'b0;
      wait_for_results();
      repeat (8) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= sel;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (sel == CSR_FRAME_WIDTH) model_width = data[FW_BITS-1:0];
      else model_height = data;
      next_col = 0;
      next_row = 0;
   endtask

   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_ready     <= 1'b1;
         rx_stall_left <= 0;
      end else if (rx_stall_left != 0) begin
         rsp_ready     <= 1'b0;
         rx_stall_left <= rx_stall_left - 1;
      end else if ($urandom_range(0, 99) < rx_idle_pct) begin
         rsp_ready     <= 1'b0;
         rx_stall_left <= $urandom_range(0, 14);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_results
      laplace_result_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result word, expected none, got value %0d col %0d row %0d",
                     $time, rsp_laplace_value, rsp_out_col, rsp_out_row);
         end else begin
            want = pending_results.pop_front();
            compare_field("laplace_value", want.value, rsp_laplace_value);
            compare_field("out_col", want.col, rsp_out_col);
            compare_field("out_row", want.row, rsp_out_row);
            compare_field("last_in_run", want.last, rsp_last_in_run);
            compare_field("end_of_frame", want.eof, rsp_end_of_frame);
         end
      end
   end

   initial begin
      stim_row_t           dir_rows[$];
      int                  random_items;
      int                  count;
      int                  frame_len;
      logic [CSR_BITS-1:0] wd;
      logic [CSR_BITS-1:0] hd;

      model_width  = FW_BITS'(RESET_WIDTH);
      model_height = ROW_BITS'(RESET_HEIGHT);
      next_col = 0;
      next_row = 0;
      foreach (upper_rows[i]) begin
         upper_rows[i]  = '0;
         middle_rows[i] = '0;
      end

      // Reset frame is 640 wide, so its first words only fill the top row.
      dir_rows.push_back(pix_none(16'h1234));
      dir_rows.push_back(pix_none(16'hABCD));
      // Width and height below two both count as two.
      dir_rows.push_back(csr_row(CSR_FRAME_WIDTH, 16'h0000));
      dir_rows.push_back(csr_row(CSR_FRAME_HEIGHT, 16'h0001));
      // Bright top-left pixel on black: the largest positive response.
      dir_rows.push_back(pix_none(16'hFFFF));
      dir_rows.push_back(pix_none(16'h0000));
      dir_rows.push_back(pix_one(16'h0000, 262140, 0, 0, 1'b0));
      dir_rows.push_back(pix_row(16'h0000));
      // Dark top-left pixel with bright neighbors: the most negative response.
      dir_rows.push_back(pix_none(16'h0000));
      dir_rows.push_back(pix_none(16'hFFFF));
      dir_rows.push_back(pix_one(16'hFFFF, -262140, 0, 0, 1'b0));
      dir_rows.push_back(pix_row(16'h0000));
      // Upper bits of the width write are dropped, leaving a width of three.
      dir_rows.push_back(csr_row(CSR_FRAME_WIDTH, 16'hF803));
      dir_rows.push_back(csr_row(CSR_FRAME_HEIGHT, 16'hFFFF));
      dir_rows.push_back(pix_row(16'h0000));
      dir_rows.push_back(pix_row(16'hFFFF));
      dir_rows.push_back(pix_row(16'h8000));
      dir_rows.push_back(pix_row(16'h7FFF));
      dir_rows.push_back(pix_row(16'h0001));
      dir_rows.push_back(pix_row(16'hFFFE));
      dir_rows.push_back(pix_row(16'h00FF));
      // Width above the line store size clamps to its full depth.
      dir_rows.push_back(csr_row(CSR_FRAME_WIDTH, 16'h07FF));
      dir_rows.push_back(csr_row(CSR_FRAME_HEIGHT, 16'h0003));
      dir_rows.push_back(pix_none(16'h5555));
      dir_rows.push_back(pix_none(16'hAAAA));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      tx_idle_pct = 15;
      rx_idle_pct <= 10;
      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CSR)
            write_register(dir_rows[i].csr_sel, dir_rows[i].data);
         else
            send_pixel(dir_rows[i].data, dir_rows[i].typed, dir_rows[i].typed_hit,
                       dir_rows[i].typed_res);
      end

      random_items = 0;
      while (random_items < 90) begin
         if (random_items >= 70) begin
            quiet       <= 1'b1;
            rx_idle_pct <= 0;
            tx_idle_pct = 0;
         end else begin
            case ($urandom_range(0, 2))
               0: tx_idle_pct = 0;
               1: tx_idle_pct = 8;
               default: tx_idle_pct = 30;
            endcase
            rx_idle_pct <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
         end
         if ($urandom_range(0, 9) == 0)
            wd = (CSR_BITS'($urandom_range(0, 31)) << FW_BITS) |
                 CSR_BITS'($urandom_range(0, 1));
         else
            wd = CSR_BITS'($urandom_range(2, 6));
         hd = ($urandom_range(0, 9) == 0) ? CSR_BITS'($urandom_range(0, 1))
                                          : CSR_BITS'($urandom_range(2, 5));
         case ($urandom_range(0, 3))
            0: write_register(CSR_FRAME_WIDTH, wd);
            1: write_register(CSR_FRAME_HEIGHT, hd);
            2: begin
               write_register(CSR_FRAME_HEIGHT, hd);
               write_register(CSR_FRAME_WIDTH, wd);
            end
            default: begin
               write_register(CSR_FRAME_WIDTH, wd);
               write_register(CSR_FRAME_HEIGHT, hd);
            end
         endcase
         frame_len = eff_width() * eff_height();
         // Mostly whole frames; now and then a frame cut short by the next write.
         if ($urandom_range(0, 4) == 0) count = $urandom_range(1, frame_len - 1);
         else count = frame_len * $urandom_range(1, 2);
         if (count > 90 - random_items) count = 90 - random_items;
         for (int k = 0; k < count; k++) begin
            if (random_items < 70 && $urandom_range(0, 29) == 0) begin
               req_valid <= 1'b0;
               wait_for_results();
            end
            send_pixel(rand_pixel(), 1'b0, 1'b0, '0);
         end
         random_items += count;
      end

      req_valid <= 1'b0;
      wait_for_results();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("laplacian_cross_stencil_core test passed");
      else
         $display("laplacian_cross_stencil_core test failed");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("laplacian_cross_stencil_core test failed");
      $finish;
   end

endmodule

>>> laplacian_cross_stencil_core.f
+incdir+src
src/lcs_pkg.sv
src/lcs_ram.sv
src/lcs_scan.sv
src/lcs_emit.sv
src/laplacian_cross_stencil_core.sv
src/lcs_checker.sv
tb/laplacian_cross_stencil_core_tb.sv
